// ----- rtl/evse_pkg.sv -----
// shared constants, types and codes of the event stream time base encoder
`timescale 1ns / 1ps
package evse_pkg;

  localparam int REL_TS_BITS     = 23;
  localparam int TYPE_BITS       = 2;
  localparam int ABS_TS_BITS     = 46;
  localparam int WORD_BYTES      = 6;
  localparam int COORD_BITS      = 11;
  localparam int TRIGGER_ID_BITS = 8;

  localparam int WORD_BITS = WORD_BYTES * 8;
  localparam int CNT_BITS  = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int TB_BITS   = TYPE_BITS + ABS_TS_BITS;
  localparam int CHG_BITS  = TYPE_BITS + REL_TS_BITS + 1 + 2 * COORD_BITS;
  localparam int TRG_BITS  = TYPE_BITS + REL_TS_BITS + 1 + TRIGGER_ID_BITS;
  localparam int HI_BITS   = ABS_TS_BITS - REL_TS_BITS;

  localparam int OP_BITS      = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_BITS     = TYPE_BITS;

  localparam int Q_DEPTH    = 2;
  localparam int QPTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_BITS  = $clog2(Q_DEPTH + 1);

  localparam logic [TYPE_BITS-1:0] CODE_TB_RST  = TYPE_BITS'(0);
  localparam logic [TYPE_BITS-1:0] CODE_CHG_RST = TYPE_BITS'(1);
  localparam logic [TYPE_BITS-1:0] CODE_TRG_RST = TYPE_BITS'(2);

  typedef enum logic [OP_BITS-1:0] {
    OP_START   = 2'd0,
    OP_CHANGE  = 2'd1,
    OP_TRIGGER = 2'd2,
    OP_INVALID = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CODE_TB  = 2'd0,
    CFG_CODE_CHG = 2'd1,
    CFG_CODE_TRG = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TB,
    BK_EV,
    BK_ERR
  } back_state_e;

  typedef struct packed {
    logic                 err;
    logic                 send_tb;
    logic                 send_ev;
    logic [WORD_BITS-1:0] tb_word;
    logic [WORD_BITS-1:0] ev_word;
  } entry_t;

endpackage

// ----- rtl/evse_if.sv -----
// stream interfaces for event items and output bytes
`timescale 1ns / 1ps
interface evse_in_if;
  logic                                valid;
  logic                                ready;
  logic [evse_pkg::OP_BITS-1:0]         operation;
  logic [evse_pkg::ABS_TS_BITS-1:0]     timestamp;
  logic                                polarity;
  logic [evse_pkg::COORD_BITS-1:0]      x_coord;
  logic [evse_pkg::COORD_BITS-1:0]      y_coord;
  logic [evse_pkg::TRIGGER_ID_BITS-1:0] trigger_id;

  modport source (output valid, operation, timestamp, polarity, x_coord, y_coord, trigger_id,
                  input ready);
  modport sink (input valid, operation, timestamp, polarity, x_coord, y_coord, trigger_id,
                output ready);
endinterface

interface evse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink (input valid, out_byte, last, error, output ready);
endinterface

// ----- rtl/evse_front.sv -----
// front end: config registers, time base tracking and word packing
`timescale 1ns / 1ps
module evse_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  evse_in_if.sink                             evt_i,
  input  logic                                cfg_we_i,
  input  logic [evse_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [evse_pkg::CFG_BITS-1:0]       cfg_data_i,
  output logic                                push_valid_o,
  output evse_pkg::entry_t                    push_entry_o,
  input  logic                                push_ready_i
);

  logic [evse_pkg::TYPE_BITS-1:0]   code_tb_q, code_chg_q, code_trg_q;
  logic [evse_pkg::ABS_TS_BITS-1:0] tb_q, tb_d;

  logic                               xfer;
  logic                               below;
  logic                               advance;
  logic [evse_pkg::ABS_TS_BITS-1:0]   delta;
  logic [evse_pkg::REL_TS_BITS-1:0]   rel_ts;
  logic [evse_pkg::HI_BITS-1:0]       new_hi;
  logic [evse_pkg::ABS_TS_BITS-1:0]   adv_tb;
  logic [evse_pkg::TB_BITS-1:0]       tb_vec;
  logic [evse_pkg::CHG_BITS-1:0]      chg_vec;
  logic [evse_pkg::TRG_BITS-1:0]      trg_vec;
  evse_pkg::op_e                      op;
  evse_pkg::entry_t                   entry;

  assign xfer  = evt_i.valid && evt_i.ready;
  assign evt_i.ready = push_ready_i;
  assign op    = evse_pkg::op_e'(evt_i.operation);

  // borrow out of the full-width subtract flags a timestamp below the base
  assign {below, delta} = {1'b0, evt_i.timestamp} - {1'b0, tb_q};
  assign advance = |delta[evse_pkg::ABS_TS_BITS-1:evse_pkg::REL_TS_BITS];
  assign rel_ts  = delta[evse_pkg::REL_TS_BITS-1:0];

  // advanced base keeps the old low bits, high bits from the timestamp less a borrow
  assign new_hi = evt_i.timestamp[evse_pkg::ABS_TS_BITS-1:evse_pkg::REL_TS_BITS]
                - evse_pkg::HI_BITS'(evt_i.timestamp[evse_pkg::REL_TS_BITS-1:0]
                                     < tb_q[evse_pkg::REL_TS_BITS-1:0]);
  assign adv_tb = {new_hi, tb_q[evse_pkg::REL_TS_BITS-1:0]};

  assign chg_vec = {evt_i.y_coord, evt_i.x_coord, evt_i.polarity, rel_ts, code_chg_q};
  assign trg_vec = {evt_i.trigger_id, evt_i.polarity, rel_ts, code_trg_q};
  assign tb_vec  = {tb_d, code_tb_q};

  always_comb begin
    tb_d          = tb_q;
    entry.err     = 1'b0;
    entry.send_tb = 1'b0;
    entry.send_ev = 1'b0;
    entry.ev_word = evse_pkg::WORD_BITS'(chg_vec);
    case (op)
      evse_pkg::OP_START: begin
        tb_d          = evt_i.timestamp;
        entry.send_tb = 1'b1;
      end
      evse_pkg::OP_CHANGE, evse_pkg::OP_TRIGGER: begin
        if (below) begin
          entry.err = 1'b1;
        end else begin
          entry.send_ev = 1'b1;
          if (advance) begin
            tb_d          = adv_tb;
            entry.send_tb = 1'b1;
          end
          if (op == evse_pkg::OP_TRIGGER) begin
            entry.ev_word = evse_pkg::WORD_BITS'(trg_vec);
          end
        end
      end
      default: begin
        entry.err = 1'b1;
      end
    endcase
    entry.tb_word = evse_pkg::WORD_BITS'(tb_vec);
  end

  assign push_valid_o = evt_i.valid;
  assign push_entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_q <= '0;
    end else if (xfer) begin
      tb_q <= tb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_tb_q  <= evse_pkg::CODE_TB_RST;
      code_chg_q <= evse_pkg::CODE_CHG_RST;
      code_trg_q <= evse_pkg::CODE_TRG_RST;
    end else if (cfg_we_i) begin
      case (evse_pkg::cfg_idx_e'(cfg_idx_i))
        evse_pkg::CFG_CODE_TB:  code_tb_q  <= cfg_data_i;
        evse_pkg::CFG_CODE_CHG: code_chg_q <= cfg_data_i;
        evse_pkg::CFG_CODE_TRG: code_trg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/evse_queue.sv -----
// small queue of packed entries between front and back
`timescale 1ns / 1ps
module evse_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  evse_pkg::entry_t push_entry_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output evse_pkg::entry_t pop_entry_o,
  input  logic             pop_ready_i
);

  evse_pkg::entry_t                mem_q [evse_pkg::Q_DEPTH];
  logic [evse_pkg::QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [evse_pkg::QCNT_BITS-1:0] count_q;
  logic                           push, pop;

  assign push_ready_o = (count_q != evse_pkg::QCNT_BITS'(evse_pkg::Q_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == evse_pkg::QPTR_BITS'(evse_pkg::Q_DEPTH - 1)) ? '0
                  : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == evse_pkg::QPTR_BITS'(evse_pkg::Q_DEPTH - 1)) ? '0
                  : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/evse_back.sv -----
// back end: serializes queued words into bytes, most significant first
`timescale 1ns / 1ps
module evse_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pop_valid_i,
  input  evse_pkg::entry_t          pop_entry_i,
  output logic                      pop_ready_o,
  evse_out_if.source                byte_o
);

  evse_pkg::back_state_e           state_q, state_d;
  logic [evse_pkg::CNT_BITS-1:0]   cnt_q, cnt_d;
  evse_pkg::entry_t                cur_q, cur_d;
  logic                            xfer;
  logic                            final_byte;
  logic                            take;

  assign xfer = byte_o.valid && byte_o.ready;

  always_comb begin
    final_byte = 1'b0;
    case (state_q)
      evse_pkg::BK_ERR: final_byte = 1'b1;
      evse_pkg::BK_EV:  final_byte = (cnt_q == '0);
      evse_pkg::BK_TB:  final_byte = (cnt_q == '0) && !cur_q.send_ev;
      default:          final_byte = 1'b0;
    endcase
  end

  assign take        = (state_q == evse_pkg::BK_IDLE) || (xfer && final_byte);
  assign pop_ready_o = take;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    if (take) begin
      if (pop_valid_i) begin
        cur_d = pop_entry_i;
        cnt_d = evse_pkg::CNT_BITS'(evse_pkg::WORD_BYTES - 1);
        if (pop_entry_i.err) begin
          state_d = evse_pkg::BK_ERR;
        end else if (pop_entry_i.send_tb) begin
          state_d = evse_pkg::BK_TB;
        end else begin
          state_d = evse_pkg::BK_EV;
        end
      end else begin
        state_d = evse_pkg::BK_IDLE;
      end
    end else if (xfer) begin
      if (cnt_q == '0) begin
        // time-base word done, event word follows
        state_d = evse_pkg::BK_EV;
        cnt_d   = evse_pkg::CNT_BITS'(evse_pkg::WORD_BYTES - 1);
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_comb begin
    byte_o.valid    = (state_q != evse_pkg::BK_IDLE);
    byte_o.last     = final_byte;
    byte_o.error    = (state_q == evse_pkg::BK_ERR);
    byte_o.out_byte = '0;
    case (state_q)
      evse_pkg::BK_TB: byte_o.out_byte = cur_q.tb_word[8*cnt_q +: 8];
      evse_pkg::BK_EV: byte_o.out_byte = cur_q.ev_word[8*cnt_q +: 8];
      default:         byte_o.out_byte = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= evse_pkg::BK_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/event_stream_time_base_encoder.sv -----
// top level of the event stream time base encoder
//
//   channel  dir  transfer unit
//   evt_i    in   one event item (start, change, trigger)
//   byte_o   out  one byte of a 48-bit word, or one error byte
//   cfg_*    in   one type code register write
//
// a change or trigger yields six bytes, or twelve when a time-base word goes first; a start yields
// six and an error one; the byte-wide output sets the rate at one byte per cycle while byte_o is ready
// the front takes an item whenever the two-entry queue has room
// reset clears the time base and the queue and restores the reset type codes
// a stall on byte_o holds the current byte; the front keeps filling the queue until it is full
`timescale 1ns / 1ps
module event_stream_time_base_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  evse_in_if.sink                           evt_i,
  evse_out_if.source                        byte_o,
  input  logic                              cfg_we_i,
  input  logic [evse_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [evse_pkg::CFG_BITS-1:0]     cfg_data_i
);

  logic             push_valid, push_ready;
  evse_pkg::entry_t push_entry;
  logic             pop_valid, pop_ready;
  evse_pkg::entry_t pop_entry;

  evse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (evt_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  evse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  evse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .byte_o      (byte_o)
  );

endmodule

// ----- dv/evse_checker.sv -----
// scoreboard: predicts the encoder byte stream and compares every output transfer
`timescale 1ns / 1ps
module evse_checker
  import evse_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  evse_in_if                      evt_i,
  evse_out_if                     byte_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } out_byte_t;

  out_byte_t              expected_bytes[$];
  logic [ABS_TS_BITS-1:0] time_base_q;
  logic [TYPE_BITS-1:0]   tb_code_q;
  logic [TYPE_BITS-1:0]   chg_code_q;
  logic [TYPE_BITS-1:0]   trg_code_q;
  int unsigned            fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    fails++;
  endtask

  task automatic queue_word(input logic [WORD_BITS-1:0] word, input logic closes);
    for (int i = WORD_BYTES - 1; i >= 0; i--) begin
      expected_bytes.push_back('{data: word[i*8 +: 8], last: closes && (i == 0), err: 1'b0});
    end
  endtask

  function automatic logic [WORD_BITS-1:0] time_base_word();
    return WORD_BITS'({time_base_q, tb_code_q});
  endfunction

  task automatic encode_event(input op_e op, input logic [ABS_TS_BITS-1:0] ts,
                              input logic pol, input logic [COORD_BITS-1:0] x,
                              input logic [COORD_BITS-1:0] y,
                              input logic [TRIGGER_ID_BITS-1:0] tid);
    logic [ABS_TS_BITS-1:0] rel;
    logic [WORD_BITS-1:0]   word;
    if (op == OP_START) begin
      time_base_q = ts;
      queue_word(time_base_word(), 1'b1);
    end else if (op == OP_INVALID || ts < time_base_q) begin
      expected_bytes.push_back('{data: 8'h00, last: 1'b1, err: 1'b1});
    end else begin
      rel = ts - time_base_q;
      // base moves in whole steps, then a time-base word goes first
      if (rel[ABS_TS_BITS-1:REL_TS_BITS] != '0) begin
        time_base_q = time_base_q + {rel[ABS_TS_BITS-1:REL_TS_BITS], REL_TS_BITS'(0)};
        queue_word(time_base_word(), 1'b0);
      end
      if (op == OP_CHANGE)
        word = WORD_BITS'({y, x, pol, rel[REL_TS_BITS-1:0], chg_code_q});
      else
        word = WORD_BITS'({tid, pol, rel[REL_TS_BITS-1:0], trg_code_q});
      queue_word(word, 1'b1);
    end
  endtask

  task automatic check_byte();
    out_byte_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch("unexpected byte", byte_i.out_byte, 8'h00);
      return;
    end
    want = expected_bytes.pop_front();
    if (byte_i.out_byte !== want.data) report_mismatch("out_byte", byte_i.out_byte, want.data);
    if (byte_i.last !== want.last) report_mismatch("last", 8'(byte_i.last), 8'(want.last));
    if (byte_i.error !== want.err) report_mismatch("error", 8'(byte_i.error), 8'(want.err));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_base_q = '0;
      tb_code_q   = CODE_TB_RST;
      chg_code_q  = CODE_CHG_RST;
      trg_code_q  = CODE_TRG_RST;
      expected_bytes.delete();
    end else begin
      if (byte_i.valid && byte_i.ready) check_byte();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CODE_TB:  tb_code_q = cfg_data_i;
          CFG_CODE_CHG: chg_code_q = cfg_data_i;
          CFG_CODE_TRG: trg_code_q = cfg_data_i;
          default: ;
        endcase
      end
      if (evt_i.valid && evt_i.ready) begin
        encode_event(op_e'(evt_i.operation), evt_i.timestamp, evt_i.polarity, evt_i.x_coord,
                     evt_i.y_coord, evt_i.trigger_id);
      end
    end
    pending_o = expected_bytes.size();
  end

endmodule

// ----- dv/testbench.sv -----
// top of the encoder testbench: clock, reset, event stimulus, byte sink and verdict
`timescale 1ns / 1ps
module testbench;
  import evse_pkg::*;

  localparam logic [ABS_TS_BITS-1:0] STEP   = ABS_TS_BITS'(1) << REL_TS_BITS;
  localparam logic [ABS_TS_BITS-1:0] TS_MAX = '1;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 28;
  localparam int BURST_ITEMS   = 20;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_BITS-1:0]     cfg_data_i;
  int unsigned             fail_count;
  int unsigned             pending;
  bit                      tx_gaps = 1'b1;
  bit                      rx_steady = 1'b0;
  bit                      hold_req = 1'b0;
  logic [ABS_TS_BITS-1:0]  cursor = '0;
  logic [ABS_TS_BITS-1:0]  last_start = '0;

  evse_in_if  evt_if ();
  evse_out_if byte_if ();

  event_stream_time_base_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_if),
    .byte_o     (byte_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  evse_checker u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (evt_if),
    .byte_i       (byte_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #8ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [ABS_TS_BITS-1:0] rand_ts();
    return ABS_TS_BITS'({$urandom(), $urandom()});
  endfunction

  // byte sink: random stalls, steady stretches and one long hold-off
  initial begin
    int unsigned stall;
    bit          hold_done;
    stall     = 0;
    hold_done = 1'b0;
    byte_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        byte_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        byte_if.ready <= 1'b1;
      end else if (stall != 0) begin
        byte_if.ready <= 1'b0;
        stall--;
      end else begin
        byte_if.ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  task automatic send_event(input op_e op, input logic [ABS_TS_BITS-1:0] ts, input logic pol,
                            input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic [TRIGGER_ID_BITS-1:0] tid);
    evt_if.valid      <= 1'b1;
    evt_if.operation  <= op;
    evt_if.timestamp  <= ts;
    evt_if.polarity   <= pol;
    evt_if.x_coord    <= x;
    evt_if.y_coord    <= y;
    evt_if.trigger_id <= tid;
    do @(negedge clk_i); while (!evt_if.ready);
    @(posedge clk_i);
    if (tx_gaps && $urandom_range(0, 2) == 0) begin
      evt_if.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    evt_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_codes(input logic [TYPE_BITS-1:0] tb, input logic [TYPE_BITS-1:0] chg,
                            input logic [TYPE_BITS-1:0] trg);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CODE_TB;
    cfg_data_i <= tb;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CODE_CHG;
    cfg_data_i <= chg;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CODE_TRG;
    cfg_data_i <= trg;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // mostly monotonic event times near the base, some starts, errors and invalid ops
  task automatic random_event();
    int unsigned            pick;
    int unsigned            hop;
    logic [ABS_TS_BITS:0]   next_ts;
    logic [ABS_TS_BITS-1:0] ts;
    op_e                    op;
    pick = $urandom_range(0, 19);
    hop  = $urandom_range(0, 9);
    if (hop < 6)
      next_ts = cursor + $urandom_range(0, 1 << 16);
    else if (hop < 8)
      next_ts = cursor + $urandom_range(0, 1 << 24);
    else if (hop == 8)
      next_ts = cursor + (rand_ts() >> $urandom_range(10, 45));
    else
      next_ts = cursor + STEP;
    if (pick < 2 || next_ts[ABS_TS_BITS]) begin
      op = OP_START;
      ts = $urandom_range(0, 1) ? rand_ts() : rand_ts() >> $urandom_range(1, 45);
      cursor     = ts;
      last_start = ts;
    end else if (pick == 18) begin
      op = OP_INVALID;
      ts = rand_ts();
    end else if (pick == 19 && last_start != '0) begin
      op = $urandom_range(0, 1) ? OP_CHANGE : OP_TRIGGER;
      ts = rand_ts() % last_start;
    end else begin
      op     = (pick < 10) ? OP_CHANGE : OP_TRIGGER;
      ts     = next_ts[ABS_TS_BITS-1:0];
      cursor = ts;
    end
    send_event(op, ts, 1'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
               TRIGGER_ID_BITS'($urandom));
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_CODE_TB;
    cfg_data_i        <= '0;
    evt_if.valid      <= 1'b0;
    evt_if.operation  <= OP_START;
    evt_if.timestamp  <= '0;
    evt_if.polarity   <= 1'b0;
    evt_if.x_coord    <= '0;
    evt_if.y_coord    <= '0;
    evt_if.trigger_id <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items under the reset type codes
    send_event(OP_CHANGE, '0, 1'b0, '0, '0, TRIGGER_ID_BITS'($urandom));
    send_event(OP_CHANGE, STEP - 1, 1'b1, '1, '1, '0);
    send_event(OP_TRIGGER, STEP, 1'b1, COORD_BITS'($urandom), COORD_BITS'($urandom), '1);
    send_event(OP_TRIGGER, 46'd5, 1'b0, '0, '0, 8'h5a);
    send_event(OP_INVALID, rand_ts(), 1'b1, COORD_BITS'($urandom), COORD_BITS'($urandom),
               TRIGGER_ID_BITS'($urandom));
    send_event(OP_START, TS_MAX, 1'b1, '1, '1, '1);
    send_event(OP_CHANGE, TS_MAX, 1'b1, '1, '1, '1);
    send_event(OP_TRIGGER, TS_MAX - 1, 1'b0, '0, '0, '0);
    send_event(OP_START, '0, 1'b0, '0, '0, '0);
    send_event(OP_CHANGE, TS_MAX, 1'b0, 11'h2aa, 11'h555, '0);
    send_event(OP_START, 46'd1000, 1'b0, '0, '0, '0);
    send_event(OP_CHANGE, 46'd999, 1'b1, '1, '0, '0);
    send_event(OP_TRIGGER, 46'd1000 + STEP - 1, 1'b1, '0, '0, 8'ha5);
    send_event(OP_TRIGGER, 46'd1000 + STEP, 1'b0, '0, '0, 8'h3c);
    send_event(OP_CHANGE, 46'd1000 + 5 * STEP + 7, 1'b1, 11'h555, 11'h2aa, '0);
    send_event(OP_TRIGGER, 46'd1000 + 5 * STEP + 7, 1'b0, '1, '1, '0);
    send_event(OP_INVALID, TS_MAX, 1'b1, '1, '1, '1);
    send_event(OP_START, {23{2'b10}}, 1'b0, '0, '0, '0);
    send_event(OP_START, {23{2'b01}}, 1'b1, '1, '1, '1);

    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: load_codes(CODE_TB_RST, CODE_CHG_RST, CODE_TRG_RST);
        1: load_codes('1, '1, '1);
        2: load_codes('0, '0, '0);
        default: load_codes(TYPE_BITS'($urandom), TYPE_BITS'($urandom), TYPE_BITS'($urandom));
      endcase
      tx_gaps   = (phase != 2);
      rx_steady = (phase == 2);
      if (phase == 1) begin
        // sink holds off while the source keeps offering back to back
        hold_req = 1'b1;
        tx_gaps  = 1'b0;
        repeat (BURST_ITEMS) random_event();
        tx_gaps  = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_event();
        if (phase == 3 && n == PHASE_ITEMS / 2) wait_idle();
      end
    end
    wait_idle();

    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
